>>> rtl/core/assert_macros.svh
// assertion macros used by the sgr decoder engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled while in reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/core/sgra_pkg.sv
// shared types and constants of the sgr attribute decoder
`timescale 1ns / 1ps

package sgra_pkg;

  localparam int unsigned COLOR_W = 25;

  localparam logic [COLOR_W-1:0] COLOR_DEFAULT = 25'd256;

  // one parameter word after range reduction
  typedef struct packed {
    logic       byte_ok;   // value below 256
    logic [7:0] low;
    logic       colon;
    logic       last;
  } sgra_item_t;

  typedef struct packed {
    logic signed [1:0]  weight;
    logic               italic;
    logic [2:0]         uline;
    logic               reverse;
    logic               invisible;
    logic               strike;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic [COLOR_W-1:0] ul_color;
    logic               ul_colored;
  } sgra_attr_t;

  typedef struct packed {
    sgra_attr_t attr;
    logic       bad;
  } sgra_result_t;

  localparam sgra_attr_t ATTR_RESET = '{
    weight:     2'sd0,
    italic:     1'b0,
    uline:      3'd0,
    reverse:    1'b0,
    invisible:  1'b0,
    strike:     1'b0,
    fg_color:   COLOR_DEFAULT,
    bg_color:   COLOR_DEFAULT,
    ul_color:   '0,
    ul_colored: 1'b0
  };

endpackage

>>> rtl/core/sgra_in_reg.sv
// input register: takes one parameter word and reduces it to a byte and a range flag
`timescale 1ns / 1ps

module sgra_in_reg
  import sgra_pkg::*;
#(
  parameter int unsigned PARAM_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PARAM_BITS-1:0] in_param_value,
  input  logic                  in_colon_follows,
  input  logic                  in_last_param,
  input  logic                  pop,
  output logic                  item_valid,
  output sgra_item_t            item
);

  logic       valid_r;
  sgra_item_t item_r;

  assign in_ready   = !valid_r || pop;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_r.byte_ok <= ~|in_param_value[PARAM_BITS-1:8];
      item_r.low     <= in_param_value[7:0];
      item_r.colon   <= in_colon_follows;
      item_r.last    <= in_last_param;
    end
  end

endmodule

>>> rtl/core/sgra_engine.sv
// sgr code decode, pending color form state and attribute registers
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sgra_engine
  import sgra_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  sgra_item_t   item,
  output sgra_result_t res
);

  localparam logic [7:0] C_RESET      = 8'd0;
  localparam logic [7:0] C_BOLD       = 8'd1;
  localparam logic [7:0] C_FAINT      = 8'd2;
  localparam logic [7:0] C_ITALIC     = 8'd3;
  localparam logic [7:0] C_ULINE      = 8'd4;
  localparam logic [7:0] C_BLINK      = 8'd5;
  localparam logic [7:0] C_BLINK_FAST = 8'd6;
  localparam logic [7:0] C_REVERSE    = 8'd7;
  localparam logic [7:0] C_HIDE       = 8'd8;
  localparam logic [7:0] C_STRIKE     = 8'd9;
  localparam logic [7:0] C_DBL_ULINE  = 8'd21;
  localparam logic [7:0] C_NORMAL     = 8'd22;
  localparam logic [7:0] C_NO_ITALIC  = 8'd23;
  localparam logic [7:0] C_NO_ULINE   = 8'd24;
  localparam logic [7:0] C_NO_BLINK   = 8'd25;
  localparam logic [7:0] C_NO_REVERSE = 8'd27;
  localparam logic [7:0] C_NO_HIDE    = 8'd28;
  localparam logic [7:0] C_NO_STRIKE  = 8'd29;
  localparam logic [7:0] C_FG_LO      = 8'd30;
  localparam logic [7:0] C_FG_HI      = 8'd37;
  localparam logic [7:0] C_FG_EXT     = 8'd38;
  localparam logic [7:0] C_FG_DEF     = 8'd39;
  localparam logic [7:0] C_BG_LO      = 8'd40;
  localparam logic [7:0] C_BG_HI      = 8'd47;
  localparam logic [7:0] C_BG_EXT     = 8'd48;
  localparam logic [7:0] C_BG_DEF     = 8'd49;
  localparam logic [7:0] C_UL_EXT     = 8'd58;
  localparam logic [7:0] C_UL_DEF     = 8'd59;
  localparam logic [7:0] C_FGB_LO     = 8'd90;
  localparam logic [7:0] C_FGB_HI     = 8'd97;
  localparam logic [7:0] C_BGB_LO     = 8'd100;
  localparam logic [7:0] C_BGB_HI     = 8'd107;
  localparam logic [7:0] C_TYPE_IDX   = 8'd5;
  localparam logic [7:0] C_TYPE_RGB   = 8'd2;
  localparam logic [7:0] C_UL_MAX     = 8'd5;

  localparam logic signed [1:0] W_NORMAL = 2'sd0;
  localparam logic signed [1:0] W_BOLD   = 2'sd1;
  localparam logic signed [1:0] W_FAINT  = -2'sd1;

  localparam logic [2:0] UL_NONE   = 3'd0;
  localparam logic [2:0] UL_SINGLE = 3'd1;
  localparam logic [2:0] UL_DOUBLE = 3'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TYPE,
    ST_INDEX,
    ST_RED,
    ST_GREEN,
    ST_BLUE,
    ST_ULTYPE,
    ST_SKIP,
    ST_GREEN_BAD,
    ST_BLUE_BAD
  } state_t;

  typedef enum logic [1:0] {
    TGT_FORE,
    TGT_BACK,
    TGT_UNDER
  } target_t;

  state_t     state_r,  state_nxt;
  target_t    target_r, target_nxt;
  sgra_attr_t attr_r,   attr_nxt;
  logic [7:0] red_r,    red_nxt;
  logic [7:0] green_r,  green_nxt;

  always_comb begin
    logic               bad;
    logic               done;
    logic               store;
    logic [COLOR_W-1:0] word;

    state_nxt  = state_r;
    target_nxt = target_r;
    attr_nxt   = attr_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    bad        = 1'b0;
    done       = 1'b0;
    store      = 1'b0;
    word       = '0;

    unique case (state_r)
      ST_IDLE: begin
        done = 1'b1;
        if (!item.byte_ok) begin
          bad = 1'b1;
        end else begin
          unique case (item.low) inside
            [C_FG_LO:C_FG_HI]:   attr_nxt.fg_color = {17'd0, item.low - C_FG_LO};
            [C_BG_LO:C_BG_HI]:   attr_nxt.bg_color = {17'd0, item.low - C_BG_LO};
            [C_FGB_LO:C_FGB_HI]: attr_nxt.fg_color = {17'd0, item.low - C_FGB_LO + 8'd8};
            [C_BGB_LO:C_BGB_HI]: attr_nxt.bg_color = {17'd0, item.low - C_BGB_LO + 8'd8};
            C_RESET:      attr_nxt = ATTR_RESET;
            C_BOLD:       attr_nxt.weight = W_BOLD;
            C_FAINT:      attr_nxt.weight = W_FAINT;
            C_ITALIC:     attr_nxt.italic = 1'b1;
            C_ULINE: begin
              if (item.colon) begin
                state_nxt = ST_ULTYPE;
                done      = 1'b0;
              end else begin
                attr_nxt.uline = UL_SINGLE;
              end
            end
            C_BLINK, C_BLINK_FAST, C_NO_BLINK: ;
            C_REVERSE:    attr_nxt.reverse = 1'b1;
            C_HIDE:       attr_nxt.invisible = 1'b1;
            C_STRIKE:     attr_nxt.strike = 1'b1;
            C_DBL_ULINE:  attr_nxt.uline = UL_DOUBLE;
            C_NORMAL:     attr_nxt.weight = W_NORMAL;
            C_NO_ITALIC:  attr_nxt.italic = 1'b0;
            C_NO_ULINE:   attr_nxt.uline = UL_NONE;
            C_NO_REVERSE: attr_nxt.reverse = 1'b0;
            C_NO_HIDE:    attr_nxt.invisible = 1'b0;
            C_NO_STRIKE:  attr_nxt.strike = 1'b0;
            C_FG_EXT, C_BG_EXT, C_UL_EXT: begin
              target_nxt = (item.low == C_FG_EXT) ? TGT_FORE :
                           (item.low == C_BG_EXT) ? TGT_BACK : TGT_UNDER;
              state_nxt  = ST_TYPE;
              done       = 1'b0;
            end
            C_FG_DEF:     attr_nxt.fg_color = COLOR_DEFAULT;
            C_BG_DEF:     attr_nxt.bg_color = COLOR_DEFAULT;
            C_UL_DEF: begin
              attr_nxt.ul_colored = 1'b0;
              attr_nxt.ul_color   = '0;
            end
            default:      bad = 1'b1;
          endcase
        end
      end
      ST_TYPE: begin
        if (item.byte_ok && item.low == C_TYPE_IDX) begin
          state_nxt = ST_INDEX;
        end else if (item.byte_ok && item.low == C_TYPE_RGB) begin
          state_nxt = ST_RED;
        end else begin
          bad  = 1'b1;
          done = 1'b1;
        end
      end
      ST_INDEX: begin
        done  = 1'b1;
        bad   = !item.byte_ok;
        store = item.byte_ok;
        word  = {17'd0, item.low};
      end
      ST_RED: begin
        red_nxt   = item.low;
        state_nxt = item.byte_ok ? ST_GREEN : ST_GREEN_BAD;
      end
      ST_GREEN: begin
        green_nxt = item.low;
        state_nxt = item.byte_ok ? ST_BLUE : ST_BLUE_BAD;
      end
      ST_GREEN_BAD: state_nxt = ST_BLUE_BAD;
      ST_BLUE: begin
        done  = 1'b1;
        bad   = !item.byte_ok;
        store = item.byte_ok;
        word  = {1'b1, red_r, green_r, item.low};
      end
      ST_BLUE_BAD: begin
        bad  = 1'b1;
        done = 1'b1;
      end
      ST_ULTYPE: begin
        done = 1'b1;
        // types above five are silently ignored
        if (item.byte_ok && item.low <= C_UL_MAX) begin
          attr_nxt.uline = item.low[2:0];
        end
      end
      ST_SKIP: begin
        if (!item.colon) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (store) begin
      case (target_r)
        TGT_FORE:  attr_nxt.fg_color = word;
        TGT_BACK:  attr_nxt.bg_color = word;
        TGT_UNDER: begin
          attr_nxt.ul_color   = word;
          attr_nxt.ul_colored = 1'b1;
        end
        default: ;
      endcase
    end

    // a colon after a finished command opens a group to skip
    if (done) begin
      state_nxt = item.colon ? ST_SKIP : ST_IDLE;
    end

    // end of sequence drops any unfinished form
    if (item.last) begin
      if (state_nxt != ST_IDLE && state_nxt != ST_SKIP) begin
        bad = 1'b1;
      end
      state_nxt = ST_IDLE;
    end

    res.attr = attr_nxt;
    res.bad  = bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      target_r <= TGT_FORE;
      attr_r   <= ATTR_RESET;
      red_r    <= '0;
      green_r  <= '0;
    end else if (adv) begin
      state_r  <= state_nxt;
      target_r <= target_nxt;
      attr_r   <= attr_nxt;
      red_r    <= red_nxt;
      green_r  <= green_nxt;
    end
  end

  `ASSERT_NXT(a_last_idle, clk, rst_n, adv && item.last, state_r == ST_IDLE, "sequence end left a pending form")
  `ASSERT_NXT(a_hold, clk, rst_n, !adv, $stable(state_r) && $stable(attr_r), "state moved without a word")
  `ASSERT_IMP(a_ul_clear, clk, rst_n, !attr_r.ul_colored, attr_r.ul_color == '0, "underline color set while not colored")
  `ASSERT_IMP(a_weight, clk, rst_n, 1'b1, attr_r.weight != 2'b10, "weight holds an unused code")

endmodule

>>> rtl/core/sgr_attribute_decoder.sv
// sgr attribute decoder top level: input register, decode engine, result register
// a word in the input register is decoded and loaded into the result register once that is empty or being drained
// throughput: one word per cycle while the result register keeps draining, with a single decode pass between registers
// the input register refills in the same cycle its word moves on, so stalls cost no bubbles
// reset (synchronous, active low) empties both registers and restores default attributes
`timescale 1ns / 1ps

module sgr_attribute_decoder
  import sgra_pkg::*;
#(
  parameter int unsigned PARAM_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PARAM_BITS-1:0] in_param_value,
  input  logic                  in_colon_follows,
  input  logic                  in_last_param,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [1:0]     out_weight,
  output logic                  out_italic_on,
  output logic [2:0]            out_underline_style,
  output logic                  out_reverse_on,
  output logic                  out_invisible_on,
  output logic                  out_strike_on,
  output logic [COLOR_W-1:0]    out_fore_color,
  output logic [COLOR_W-1:0]    out_back_color,
  output logic [COLOR_W-1:0]    out_uline_color,
  output logic                  out_uline_colored,
  output logic                  out_bad_param
);

  logic         item_valid;
  sgra_item_t   item;
  logic         adv;
  sgra_result_t res;
  logic         out_valid_r;
  sgra_result_t out_r;

  // a word moves on when the result register is empty or being drained
  assign adv = item_valid && (!out_valid_r || out_ready);

  sgra_in_reg #(
    .PARAM_BITS(PARAM_BITS)
  ) u_in_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_param_value  (in_param_value),
    .in_colon_follows(in_colon_follows),
    .in_last_param   (in_last_param),
    .pop             (adv),
    .item_valid      (item_valid),
    .item            (item)
  );

  sgra_engine u_engine (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (adv),
    .item (item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_weight          = out_r.attr.weight;
  assign out_italic_on       = out_r.attr.italic;
  assign out_underline_style = out_r.attr.uline;
  assign out_reverse_on      = out_r.attr.reverse;
  assign out_invisible_on    = out_r.attr.invisible;
  assign out_strike_on       = out_r.attr.strike;
  assign out_fore_color      = out_r.attr.fg_color;
  assign out_back_color      = out_r.attr.bg_color;
  assign out_uline_color     = out_r.attr.ul_color;
  assign out_uline_colored   = out_r.attr.ul_colored;
  assign out_bad_param       = out_r.bad;

endmodule

>>> test/tb_sgr_attribute_decoder.sv
// testbench for the sgr attribute decoder: directed table, random sequences, attribute predictor
`timescale 1ns / 1ps

module tb_sgr_attribute_decoder;
  import sgra_pkg::*;

  localparam logic [15:0] SGR_RESET       = 16'd0;
  localparam logic [15:0] SGR_BOLD        = 16'd1;
  localparam logic [15:0] SGR_FAINT       = 16'd2;
  localparam logic [15:0] SGR_ITALIC      = 16'd3;
  localparam logic [15:0] SGR_ULINE       = 16'd4;
  localparam logic [15:0] SGR_BLINK       = 16'd5;
  localparam logic [15:0] SGR_BLINK_FAST  = 16'd6;
  localparam logic [15:0] SGR_REVERSE     = 16'd7;
  localparam logic [15:0] SGR_HIDE        = 16'd8;
  localparam logic [15:0] SGR_STRIKE      = 16'd9;
  localparam logic [15:0] SGR_ULINE_DBL   = 16'd21;
  localparam logic [15:0] SGR_WEIGHT_OFF  = 16'd22;
  localparam logic [15:0] SGR_ITALIC_OFF  = 16'd23;
  localparam logic [15:0] SGR_ULINE_OFF   = 16'd24;
  localparam logic [15:0] SGR_BLINK_OFF   = 16'd25;
  localparam logic [15:0] SGR_REVERSE_OFF = 16'd27;
  localparam logic [15:0] SGR_HIDE_OFF    = 16'd28;
  localparam logic [15:0] SGR_STRIKE_OFF  = 16'd29;
  localparam logic [15:0] SGR_FG_BASE     = 16'd30;
  localparam logic [15:0] SGR_FG_EXT      = 16'd38;
  localparam logic [15:0] SGR_FG_DEFAULT  = 16'd39;
  localparam logic [15:0] SGR_BG_BASE     = 16'd40;
  localparam logic [15:0] SGR_BG_EXT      = 16'd48;
  localparam logic [15:0] SGR_BG_DEFAULT  = 16'd49;
  localparam logic [15:0] SGR_UL_EXT      = 16'd58;
  localparam logic [15:0] SGR_UL_DEFAULT  = 16'd59;
  localparam logic [15:0] SGR_FG_BRIGHT   = 16'd90;
  localparam logic [15:0] SGR_BG_BRIGHT   = 16'd100;
  localparam logic [15:0] BANK_COLORS     = 16'd8;
  localparam logic [15:0] CTYPE_RGB       = 16'd2;
  localparam logic [15:0] CTYPE_INDEX     = 16'd5;
  localparam logic [15:0] PALETTE_SIZE    = 16'd256;
  localparam logic [15:0] ULINE_STYLE_MAX = 16'd5;

  localparam int RANDOM_WORDS = 850;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum logic [3:0] {
    STEP_IDLE, STEP_TYPE, STEP_INDEX, STEP_RED, STEP_GREEN, STEP_BLUE,
    STEP_ULTYPE, STEP_SKIP, STEP_GREEN_BAD, STEP_BLUE_BAD
  } decode_step_t;

  typedef enum logic [1:0] {SEL_FORE, SEL_BACK, SEL_ULINE} color_sel_t;

  typedef struct packed {
    logic [15:0] value;
    logic        colon;
    logic        last;
    logic        pinned;      // expectation typed into the table
    logic        pinned_bad;
  } param_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [15:0]           in_param_value = '0;
  logic                  in_colon_follows = 1'b0;
  logic                  in_last_param = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [1:0]     out_weight;
  logic                  out_italic_on;
  logic [2:0]            out_underline_style;
  logic                  out_reverse_on;
  logic                  out_invisible_on;
  logic                  out_strike_on;
  logic [COLOR_W-1:0]    out_fore_color;
  logic [COLOR_W-1:0]    out_back_color;
  logic [COLOR_W-1:0]    out_uline_color;
  logic                  out_uline_colored;
  logic                  out_bad_param;

  sgr_attribute_decoder DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_param_value      (in_param_value),
    .in_colon_follows    (in_colon_follows),
    .in_last_param       (in_last_param),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_weight          (out_weight),
    .out_italic_on       (out_italic_on),
    .out_underline_style (out_underline_style),
    .out_reverse_on      (out_reverse_on),
    .out_invisible_on    (out_invisible_on),
    .out_strike_on       (out_strike_on),
    .out_fore_color      (out_fore_color),
    .out_back_color      (out_back_color),
    .out_uline_color     (out_uline_color),
    .out_uline_colored   (out_uline_colored),
    .out_bad_param       (out_bad_param)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  sgra_attr_t   attr_now = ATTR_RESET;
  decode_step_t step_now = STEP_IDLE;
  color_sel_t   color_sel = SEL_FORE;
  logic [7:0]   red_keep = '0;
  logic [7:0]   green_keep = '0;

  param_word_t  param_q[$];
  sgra_result_t attr_expect_q[$];
  int           total_words = 0;
  int           words_accepted = 0;
  int           words_checked = 0;
  int           mismatches = 0;

  param_word_t directed_rows [0:25] = '{
    '{16'hFFFF,      1'b0, 1'b1, 1'b1, 1'b1},  // unknown code at the top of the range
    '{SGR_FAINT,     1'b0, 1'b0, 1'b0, 1'b0},
    '{SGR_BLINK,     1'b0, 1'b0, 1'b0, 1'b0},
    '{SGR_FG_EXT,    1'b0, 1'b0, 1'b0, 1'b0},
    '{CTYPE_INDEX,   1'b0, 1'b0, 1'b0, 1'b0},
    '{16'd255,       1'b0, 1'b0, 1'b0, 1'b0},
    '{SGR_BG_EXT,    1'b0, 1'b0, 1'b0, 1'b0},
    '{CTYPE_RGB,     1'b0, 1'b0, 1'b0, 1'b0},
    '{16'd255,       1'b0, 1'b0, 1'b0, 1'b0},
    '{16'd0,         1'b0, 1'b0, 1'b0, 1'b0},
    '{16'd255,       1'b0, 1'b0, 1'b0, 1'b0},
    '{SGR_UL_EXT,    1'b0, 1'b0, 1'b0, 1'b0},
    '{CTYPE_RGB,     1'b0, 1'b0, 1'b0, 1'b0},
    '{PALETTE_SIZE,  1'b0, 1'b0, 1'b0, 1'b0},  // red out of range, rest still consumed
    '{16'd0,         1'b0, 1'b0, 1'b0, 1'b0},
    '{16'd0,         1'b0, 1'b0, 1'b0, 1'b0},
    '{SGR_BG_EXT,    1'b0, 1'b0, 1'b0, 1'b0},
    '{CTYPE_INDEX,   1'b0, 1'b0, 1'b0, 1'b0},
    '{PALETTE_SIZE,  1'b0, 1'b0, 1'b0, 1'b0},
    '{SGR_FG_EXT,    1'b0, 1'b0, 1'b0, 1'b0},
    '{16'd7,         1'b0, 1'b0, 1'b0, 1'b0},  // unknown color type
    '{SGR_ULINE,     1'b1, 1'b0, 1'b0, 1'b0},
    '{16'd7,         1'b1, 1'b0, 1'b0, 1'b0},  // style above range, then colon group
    '{SGR_BOLD,      1'b0, 1'b0, 1'b0, 1'b0},  // dropped by the colon group
    '{SGR_UL_EXT,    1'b0, 1'b1, 1'b0, 1'b0},  // form cut short by end of sequence
    '{SGR_RESET,     1'b0, 1'b1, 1'b1, 1'b0}
  };

  function automatic void paint(logic [24:0] c);
    case (color_sel)
      SEL_FORE: attr_now.fg_color = c;
      SEL_BACK: attr_now.bg_color = c;
      default: begin
        attr_now.ul_color   = c;
        attr_now.ul_colored = 1'b1;
      end
    endcase
  endfunction

  // advances the attribute state by one parameter word and returns the reported set
  function automatic sgra_result_t sgr_apply(logic [15:0] v, logic colon, logic last);
    logic bad;
    logic done;
    bad  = 1'b0;
    done = 1'b0;
    case (step_now)
      STEP_IDLE: begin
        done = 1'b1;
        if (v >= SGR_FG_BASE && v < SGR_FG_BASE + BANK_COLORS) begin
          attr_now.fg_color = 25'(v - SGR_FG_BASE);
        end else if (v >= SGR_BG_BASE && v < SGR_BG_BASE + BANK_COLORS) begin
          attr_now.bg_color = 25'(v - SGR_BG_BASE);
        end else if (v >= SGR_FG_BRIGHT && v < SGR_FG_BRIGHT + BANK_COLORS) begin
          attr_now.fg_color = 25'(v - SGR_FG_BRIGHT + BANK_COLORS);
        end else if (v >= SGR_BG_BRIGHT && v < SGR_BG_BRIGHT + BANK_COLORS) begin
          attr_now.bg_color = 25'(v - SGR_BG_BRIGHT + BANK_COLORS);
        end else begin
          case (v)
            SGR_RESET:       attr_now = ATTR_RESET;
            SGR_BOLD:        attr_now.weight = 2'sd1;
            SGR_FAINT:       attr_now.weight = -2'sd1;
            SGR_ITALIC:      attr_now.italic = 1'b1;
            SGR_ULINE: begin
              if (colon) begin
                step_now = STEP_ULTYPE;
                done     = 1'b0;
              end else begin
                attr_now.uline = 3'd1;
              end
            end
            SGR_BLINK, SGR_BLINK_FAST, SGR_BLINK_OFF: ;
            SGR_REVERSE:     attr_now.reverse = 1'b1;
            SGR_HIDE:        attr_now.invisible = 1'b1;
            SGR_STRIKE:      attr_now.strike = 1'b1;
            SGR_ULINE_DBL:   attr_now.uline = 3'd2;
            SGR_WEIGHT_OFF:  attr_now.weight = 2'sd0;
            SGR_ITALIC_OFF:  attr_now.italic = 1'b0;
            SGR_ULINE_OFF:   attr_now.uline = 3'd0;
            SGR_REVERSE_OFF: attr_now.reverse = 1'b0;
            SGR_HIDE_OFF:    attr_now.invisible = 1'b0;
            SGR_STRIKE_OFF:  attr_now.strike = 1'b0;
            SGR_FG_EXT, SGR_BG_EXT, SGR_UL_EXT: begin
              color_sel = (v == SGR_FG_EXT) ? SEL_FORE : (v == SGR_BG_EXT) ? SEL_BACK : SEL_ULINE;
              step_now  = STEP_TYPE;
              done      = 1'b0;
            end
            SGR_FG_DEFAULT:  attr_now.fg_color = COLOR_DEFAULT;
            SGR_BG_DEFAULT:  attr_now.bg_color = COLOR_DEFAULT;
            SGR_UL_DEFAULT: begin
              attr_now.ul_colored = 1'b0;
              attr_now.ul_color   = '0;
            end
            default:         bad = 1'b1;
          endcase
        end
      end
      STEP_TYPE: begin
        if (v == CTYPE_INDEX) begin
          step_now = STEP_INDEX;
        end else if (v == CTYPE_RGB) begin
          step_now = STEP_RED;
        end else begin
          bad  = 1'b1;
          done = 1'b1;
        end
      end
      STEP_INDEX: begin
        if (v < PALETTE_SIZE) paint(25'(v));
        else bad = 1'b1;
        done = 1'b1;
      end
      STEP_RED: begin
        if (v < PALETTE_SIZE) begin
          red_keep = v[7:0];
          step_now = STEP_GREEN;
        end else begin
          step_now = STEP_GREEN_BAD;
        end
      end
      STEP_GREEN: begin
        if (v < PALETTE_SIZE) begin
          green_keep = v[7:0];
          step_now   = STEP_BLUE;
        end else begin
          step_now = STEP_BLUE_BAD;
        end
      end
      STEP_GREEN_BAD: step_now = STEP_BLUE_BAD;
      STEP_BLUE: begin
        if (v < PALETTE_SIZE) paint({1'b1, red_keep, green_keep, v[7:0]});
        else bad = 1'b1;
        done = 1'b1;
      end
      STEP_BLUE_BAD: begin
        bad  = 1'b1;
        done = 1'b1;
      end
      STEP_ULTYPE: begin
        if (v <= ULINE_STYLE_MAX) attr_now.uline = v[2:0];
        done = 1'b1;
      end
      STEP_SKIP: if (!colon) step_now = STEP_IDLE;
      default: step_now = STEP_IDLE;
    endcase

    if (done) step_now = colon ? STEP_SKIP : STEP_IDLE;
    if (last) begin
      if (step_now != STEP_IDLE && step_now != STEP_SKIP) bad = 1'b1;
      step_now = STEP_IDLE;
    end
    return '{attr: attr_now, bad: bad};
  endfunction

  function automatic param_word_t mk_word(logic [15:0] v, logic c);
    return '{value: v, colon: c, last: 1'b0, pinned: 1'b0, pinned_bad: 1'b0};
  endfunction

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 29));
      1: return SGR_FG_BASE + 16'($urandom_range(0, 7));
      2: return SGR_BG_BASE + 16'($urandom_range(0, 7));
      3: return SGR_FG_BRIGHT + 16'($urandom_range(0, 7));
      4: return SGR_BG_BRIGHT + 16'($urandom_range(0, 7));
      default: begin
        case ($urandom_range(0, 4))
          0: return SGR_FG_DEFAULT;
          1: return SGR_BG_DEFAULT;
          2: return SGR_UL_DEFAULT;
          3: return 16'($urandom_range(30, 127));
          default: return SGR_RESET;
        endcase
      end
    endcase
  endfunction

  // color index or component, now and then out of range
  function automatic logic [15:0] color_part();
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(256, 65535));
    return 16'($urandom_range(0, 255));
  endfunction

  task automatic add_sequence();
    param_word_t seq[$];
    int          pick;
    int          sel;
    int          cut;
    logic [15:0] ext;
    if ($urandom_range(0, 9) == 0) begin
      // raw noise with random separators
      repeat ($urandom_range(1, 6)) seq.push_back(mk_word(16'($urandom), 1'($urandom)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 2);
        ext  = (sel == 0) ? SGR_FG_EXT : (sel == 1) ? SGR_BG_EXT : SGR_UL_EXT;
        if (pick < 40) begin
          seq.push_back(mk_word(pick_code(), 1'b0));
        end else if (pick < 58) begin
          seq.push_back(mk_word(ext, 1'b0));
          seq.push_back(mk_word(CTYPE_INDEX, 1'b0));
          seq.push_back(mk_word(color_part(), 1'b0));
        end else if (pick < 76) begin
          seq.push_back(mk_word(ext, 1'b0));
          seq.push_back(mk_word(CTYPE_RGB, 1'b0));
          repeat (3) seq.push_back(mk_word(color_part(), 1'b0));
        end else if (pick < 86) begin
          seq.push_back(mk_word(SGR_ULINE, 1'b1));
          seq.push_back(mk_word(16'($urandom_range(0, 7)), 1'b0));
        end else if (pick < 92) begin
          seq.push_back(mk_word(ext, 1'b0));
          seq.push_back(mk_word(16'($urandom), 1'b0));
        end else begin
          seq.push_back(mk_word(16'($urandom), 1'b0));
        end
        // colon group trailing the command
        if ($urandom_range(0, 6) == 0) begin
          seq[seq.size()-1].colon = 1'b1;
          repeat ($urandom_range(0, 2)) seq.push_back(mk_word(16'($urandom_range(0, 300)), 1'b1));
          seq.push_back(mk_word(16'($urandom_range(0, 300)), 1'b0));
        end
      end
    end
    // sequence ended early, often in the middle of a form
    if (seq.size() > 1 && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, seq.size() - 1);
      while (seq.size() > cut) void'(seq.pop_back());
    end
    seq[seq.size()-1].last = 1'b1;
    foreach (seq[i]) param_q.push_back(seq[i]);
  endtask

  // sender: bursts with random gaps
  int   burst_left = 0;
  int   gap_left = 0;
  logic cur_pinned = 1'b0;
  logic cur_pinned_bad = 1'b0;

  always @(posedge clk) begin : feed_params
    param_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0 || param_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        w = param_q.pop_front();
        in_valid         <= 1'b1;
        in_param_value   <= w.value;
        in_colon_follows <= w.colon;
        in_last_param    <= w.last;
        cur_pinned       <= w.pinned;
        cur_pinned_bad   <= w.pinned_bad;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk) begin : track_params
    sgra_result_t predicted;
    if (rst_n && in_valid && in_ready) begin
      predicted = sgr_apply(in_param_value, in_colon_follows, in_last_param);
      if (cur_pinned) predicted = '{attr: ATTR_RESET, bad: cur_pinned_bad};
      attr_expect_q.push_back(predicted);
      words_accepted <= words_accepted + 1;
    end
  end

  // receiver: segments of always-ready, random and rotating-pattern stalls
  int         seg_left = 0;
  logic [1:0] seg_mode = 2'd0;
  logic [7:0] stall_pat = 8'hFF;
  int         hold_left = 0;
  logic       held = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held && words_accepted >= HOLD_AFTER) begin
      // long hold-off so the block fills up and backs up the input
      held      <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_mode  <= 2'($urandom_range(0, 2));
        seg_left  <= $urandom_range(20, 100);
        stall_pat <= 8'($urandom) | 8'h01;
      end else begin
        seg_left  <= seg_left - 1;
        stall_pat <= {stall_pat[6:0], stall_pat[7]};
      end
      case (seg_mode)
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= ($urandom_range(0, 9) < 7);
        default: out_ready <= stall_pat[0];
      endcase
    end
  end

  task automatic check_field(string what, logic [24:0] want, logic [24:0] got);
    if (got !== want) begin
      if (mismatches < 10) begin
        $display("mismatch in %s of word %0d: expected %h, got %h", what, words_checked, want, got);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_attrs
    sgra_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (attr_expect_q.size() == 0) begin
        if (mismatches < 10) $display("word %0d arrived with nothing expected", words_checked);
        mismatches++;
      end else begin
        want = attr_expect_q.pop_front();
        check_field("weight", 25'(want.attr.weight), 25'(out_weight));
        check_field("italic", 25'(want.attr.italic), 25'(out_italic_on));
        check_field("underline style", 25'(want.attr.uline), 25'(out_underline_style));
        check_field("reverse", 25'(want.attr.reverse), 25'(out_reverse_on));
        check_field("invisible", 25'(want.attr.invisible), 25'(out_invisible_on));
        check_field("strike", 25'(want.attr.strike), 25'(out_strike_on));
        check_field("fore color", want.attr.fg_color, out_fore_color);
        check_field("back color", want.attr.bg_color, out_back_color);
        check_field("underline color", want.attr.ul_color, out_uline_color);
        check_field("underline colored", 25'(want.attr.ul_colored), 25'(out_uline_colored));
        check_field("bad param", 25'(want.bad), 25'(out_bad_param));
      end
      words_checked++;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[sgr_attribute_decoder] ERROR");
    $finish;
  end

  initial begin : run
    foreach (directed_rows[i]) param_q.push_back(directed_rows[i]);
    while (param_q.size() < $size(directed_rows) + RANDOM_WORDS) add_sequence();
    total_words = param_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (words_accepted != total_words) @(posedge clk);
    while (attr_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[sgr_attribute_decoder] OK");
    end else begin
      $display("[sgr_attribute_decoder] ERROR");
    end
    $finish;
  end

endmodule
